/* hw/rtl/krt_pkg.sv */
// Shared types and constants for the keyed record table.
package krt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    // Request operation codes
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_SEARCH = 3'd1,
        OP_UPDATE = 3'd2,
        OP_DELETE = 3'd3,
        OP_LIST   = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // One stored record
    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        name;
        logic [7:0]         age;
        logic [15:0]        mark;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Result register load selector
    typedef enum logic [2:0] {
        LD_NONE   = 3'd0,
        LD_INSERT = 3'd1,
        LD_MATCH  = 3'd2,
        LD_UPDATE = 3'd3,
        LD_FULL   = 3'd4,
        LD_MISS   = 3'd5,
        LD_EMPTY  = 3'd6,
        LD_LIST   = 3'd7
    } t_ld;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_SHIFT,
        S_LIST,
        S_LIST_RD,
        S_LIST_LD,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;        // latch request, rewind index
        logic step;        // issue read at index, advance
        logic shift_wr;    // write previous read one place down
        logic shift_start; // point index just past the match
        logic del_done;    // drop count, show result
        logic list_next;   // advance list index
        t_ld  ld;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic scan_done;
        logic out_taken;
        logic last;
    } t_sts;

endpackage

/* hw/rtl/krt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module krt_ram
    import krt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/krt_ctrl.sv */
// Sequencing state machine for the keyed record table.
module krt_ctrl
    import krt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_opcode,
    output logic       o_in_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_INSERT;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_in_valid) begin
                r_op <= i_opcode;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        OP_INSERT: n_state = S_INS;
                        OP_SEARCH: n_state = S_SCAN;
                        OP_UPDATE: n_state = S_SCAN;
                        OP_DELETE: n_state = S_SCAN;
                        OP_LIST:   n_state = S_LIST;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INS:  n_state = S_EMIT;
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = (r_op == OP_DELETE) ? S_SHIFT : S_EMIT;
                end else if (i_sts.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_SHIFT: begin
                if (i_sts.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_LIST:    n_state = i_sts.empty ? S_EMIT : S_LIST_RD;
            S_LIST_RD: n_state = S_LIST_LD;
            S_LIST_LD: n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.last ? S_IDLE : S_LIST_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.take        = 1'b0;
        o_cmd.step        = 1'b0;
        o_cmd.shift_wr    = 1'b0;
        o_cmd.shift_start = 1'b0;
        o_cmd.del_done    = 1'b0;
        o_cmd.list_next   = 1'b0;
        o_cmd.ld          = LD_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_INS: o_cmd.ld = i_sts.full ? LD_FULL : LD_INSERT;
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.ld          = (r_op == OP_UPDATE) ? LD_UPDATE : LD_MATCH;
                    o_cmd.shift_start = (r_op == OP_DELETE);
                end else if (i_sts.scan_done) begin
                    o_cmd.ld = LD_MISS;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.scan_done) begin
                    o_cmd.del_done = 1'b1;
                end else begin
                    o_cmd.step     = 1'b1;
                    o_cmd.shift_wr = 1'b1;
                end
            end
            S_LIST: begin
                if (i_sts.empty) begin
                    o_cmd.ld = LD_EMPTY;
                end
            end
            S_LIST_RD: ;
            S_LIST_LD: o_cmd.ld = LD_LIST;
            S_EMIT:    o_cmd.list_next = i_sts.out_taken && !i_sts.last;
            default: ;
        endcase
    end

endmodule

/* hw/rtl/krt_datapath.sv */
// Record store, scan index, count and result register.
module krt_datapath
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    input  t_rec    i_req,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_status o_status,
    output t_rec    o_rec,
    output logic    o_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_rec          r_req;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_pidx;
    logic          r_pv;
    logic          r_ovld;
    t_status       r_status;
    t_rec          r_out;
    logic          r_last;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_rec          wr_data;
    t_rec          rd_data;
    t_rec          upd_rec;
    logic          idx_lt;
    logic          out_taken;

    krt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign idx_lt    = (r_idx < r_count);
    assign out_taken = r_ovld && i_out_ready;

    always_comb begin
        upd_rec      = r_req;
        upd_rec.key  = rd_data.key;
    end

    // Single write port: append, rewrite in place, or move down one slot
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pidx;
        wr_data = rd_data;
        if (i_cmd.ld == LD_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = r_req;
        end else if (i_cmd.ld == LD_UPDATE) begin
            wr_en   = 1'b1;
            wr_data = upd_rec;
        end else if (i_cmd.shift_wr && r_pv) begin
            wr_en   = 1'b1;
            wr_addr = r_pidx - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_pv <= i_cmd.step && idx_lt;
            if (i_cmd.take) begin
                r_idx <= '0;
            end else if (i_cmd.step && idx_lt) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_cmd.shift_start) begin
                r_idx <= CW'(r_pidx) + CW'(1);
            end else if (i_cmd.list_next) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.ld == LD_INSERT) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.del_done) begin
                r_count <= r_count - CW'(1);
            end
            // delete shows its result only once the gap is closed
            if ((i_cmd.ld != LD_NONE && !i_cmd.shift_start) || i_cmd.del_done) begin
                r_ovld <= 1'b1;
            end else if (out_taken) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req <= i_req;
        end
        if (i_cmd.step && idx_lt) begin
            r_pidx <= r_idx[AW-1:0];
        end
        case (i_cmd.ld)
            LD_INSERT: begin
                r_status <= ST_OK;
                r_out    <= r_req;
                r_last   <= 1'b1;
            end
            LD_MATCH: begin
                r_status <= ST_OK;
                r_out    <= rd_data;
                r_last   <= 1'b1;
            end
            LD_UPDATE: begin
                r_status <= ST_OK;
                r_out    <= upd_rec;
                r_last   <= 1'b1;
            end
            LD_FULL: begin
                r_status <= ST_FULL;
                r_out    <= '0;
                r_last   <= 1'b1;
            end
            LD_MISS: begin
                r_status <= ST_MISS;
                r_out    <= '0;
                r_last   <= 1'b1;
            end
            LD_EMPTY: begin
                r_status <= ST_EMPTY;
                r_out    <= '0;
                r_last   <= 1'b1;
            end
            LD_LIST: begin
                r_status <= ST_OK;
                r_out    <= rd_data;
                r_last   <= ((r_idx + CW'(1)) == r_count);
            end
            default: ;
        endcase
    end

    assign o_sts.full      = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.hit       = r_pv && (rd_data.key == r_req.key);
    assign o_sts.scan_done = !r_pv && !idx_lt;
    assign o_sts.out_taken = out_taken;
    assign o_sts.last      = r_last;

    assign o_out_valid = r_ovld;
    assign o_status    = r_status;
    assign o_rec       = r_out;
    assign o_last      = r_last;

endmodule

/* hw/rtl/keyed_record_table_top.sv */
// Top level of the keyed record table: controller, datapath and assertions.
//
// Usage
// - Request channel (i_in_valid / o_in_ready) carries opcode, key, name tag, age
//   and mark. Insert appends, search/update/delete act on the oldest record
//   with a matching key, list streams every record in stored order.
// - Result channel (o_out_valid / i_out_ready) carries status and the record
//   concerned; o_last marks the final result of a request.
// - Search, update and delete scan the store one entry per cycle through the
//   single RAM read port; delete then moves each later record down one place
//   before its result is shown. List reads, loads and shows each record in
//   turn, and reads the next one only after the previous one is taken.
// - One request is in flight at a time: o_in_ready rises again once the last
//   result of the previous request has been taken. Unused opcodes are taken
//   and dropped with no result.
// - A stalled receiver simply holds the result register; nothing is lost.
// - Reset clears the record count and the control state; the store needs no
//   clearing pass, as only entries below the count are ever read.
module keyed_record_table_top
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_key,
    input  logic [63:0]        i_name_tag,
    input  logic [7:0]         i_age,
    input  logic [15:0]        i_mark_hundredths,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_found_key,
    output logic [63:0]        o_found_name,
    output logic [7:0]         o_found_age,
    output logic [15:0]        o_found_mark,
    output logic               o_last
);

    t_cmd    cmd;
    t_sts    sts;
    t_rec    req;
    t_rec    out_rec;
    t_status out_status;

    assign req.key  = i_key;
    assign req.name = i_name_tag;
    assign req.age  = i_age;
    assign req.mark = i_mark_hundredths;

    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    krt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (req),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_status    (out_status),
        .o_rec       (out_rec),
        .o_last      (o_last)
    );

    assign o_status     = out_status;
    assign o_found_key  = out_rec.key;
    assign o_found_name = out_rec.name;
    assign o_found_age  = out_rec.age;
    assign o_found_mark = out_rec.mark;

    // A result is never on show while a new request can be taken
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("result valid while accepting requests");

    // A valid opcode keeps the block busy in the following cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode <= OP_LIST) |=> !o_in_ready)
        else $error("request dropped without result");

    // Table full is only reported when the count is at depth
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && out_status == ST_FULL) |-> sts.full)
        else $error("full status with room in table");

    // Failure results carry an empty record and end the request
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && out_status != ST_OK) |-> (out_rec == '0 && o_last))
        else $error("failure result with record data");

endmodule

/* verif/tb.sv */
// Self-checking testbench for keyed_record_table_top: shadow table, random requests, stalls.
`timescale 1ns / 100ps

module tb;
    import krt_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    // number of random requests after the directed opening
    localparam int RANDOM_REQS = 230;
    // room for an ignored request still in flight after the last result
    localparam int DRAIN_CYCLES = 200;

    // opcodes above the list code are taken and dropped by the block
    localparam logic [2:0] FIRST_SPARE_OP = 3'(OP_LIST) + 3'd1;
    localparam logic [2:0] LAST_SPARE_OP  = 3'd7;

    // one request as it sits on the request channel
    typedef struct packed {
        logic [2:0] op;
        t_rec       rec;
    } t_req;

    // one result as it should appear on the result channel
    typedef struct packed {
        t_status status;
        t_rec    rec;
        logic    last;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // request channel, driven from the testbench side
    logic in_valid = 1'b0;
    t_req cur_req  = '0;
    logic o_in_ready;

    // result channel
    logic               out_ready = 1'b0;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_found_key;
    logic [63:0]        o_found_name;
    logic [7:0]         o_found_age;
    logic [15:0]        o_found_mark;
    logic               o_last;

    // requests waiting to be presented, and results the shadow table says are due
    t_req    queued_requests[$];
    t_result due_records[$];

    // shadow copy of the table, updated as each request is taken
    t_rec shadow_rec[DEPTH];
    int   shadow_count = 0;

    int reqs_taken = 0;
    int total_reqs = 1;
    bit mismatch   = 1'b0;

    keyed_record_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (cur_req.op),
        .i_key             (cur_req.rec.key),
        .i_name_tag        (cur_req.rec.name),
        .i_age             (cur_req.rec.age),
        .i_mark_hundredths (cur_req.rec.mark),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_status          (o_status),
        .o_found_key       (o_found_key),
        .o_found_name      (o_found_name),
        .o_found_age       (o_found_age),
        .o_found_mark      (o_found_mark),
        .o_last            (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one taken request to the shadow table and queue the results it
    // should produce. Lookups hit the oldest record with a matching key.
    function automatic void table_outcome(t_req r);
        int      hit;
        t_result res;
        hit = -1;
        for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_rec[i].key == r.rec.key) hit = i;
        end
        res = '{status: ST_OK, rec: '0, last: 1'b1};
        case (r.op)
            OP_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_rec[shadow_count] = r.rec;
                    shadow_count++;
                    res.rec = r.rec;
                end
                due_records.push_back(res);
            end
            OP_SEARCH: begin
                if (hit < 0) res.status = ST_MISS;
                else         res.rec = shadow_rec[hit];
                due_records.push_back(res);
            end
            OP_UPDATE: begin
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    // key stays, payload is rewritten
                    shadow_rec[hit].name = r.rec.name;
                    shadow_rec[hit].age  = r.rec.age;
                    shadow_rec[hit].mark = r.rec.mark;
                    res.rec = shadow_rec[hit];
                end
                due_records.push_back(res);
            end
            OP_DELETE: begin
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    res.rec = shadow_rec[hit];
                    // close the gap: later records move down one place
                    for (int j = hit; j + 1 < shadow_count; j++)
                        shadow_rec[j] = shadow_rec[j + 1];
                    shadow_count--;
                end
                due_records.push_back(res);
            end
            OP_LIST: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                    due_records.push_back(res);
                end else begin
                    for (int j = 0; j < shadow_count; j++) begin
                        res.rec  = shadow_rec[j];
                        res.last = (j == shadow_count - 1);
                        due_records.push_back(res);
                    end
                end
            end
            default: ; // spare opcode: no result, no change
        endcase
    endfunction

    // Stall share in percent. The run is split in thirds by requests taken:
    // sender 38 / receiver 62, then swapped, then no stalls at all.
    function automatic int stall_share(bit for_sender);
        case ((reqs_taken * 3) / total_reqs)
            0:       return for_sender ? 38 : 62;
            1:       return for_sender ? 62 : 38;
            default: return 0;
        endcase
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            mismatch = 1'b1;
        end
    endfunction

    // Request driver: holds valid and payload until taken, then either
    // presents the next queued request or drops valid.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                table_outcome(cur_req);
                reqs_taken <= reqs_taken + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (queued_requests.size() > 0 &&
                    $urandom_range(0, 99) >= stall_share(1'b1)) begin
                    cur_req  <= queued_requests.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every taken result is matched against the oldest one due.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (due_records.size() == 0) begin
                    $error("result with none due: status %0h key %0h", o_status, o_found_key);
                    mismatch = 1'b1;
                end else begin
                    want = due_records.pop_front();
                    check_field("status", 64'(want.status), 64'(o_status));
                    check_field("found_key", 64'(want.rec.key), 64'(o_found_key));
                    check_field("found_name", want.rec.name, o_found_name);
                    check_field("found_age", 64'(want.rec.age), 64'(o_found_age));
                    check_field("found_mark", 64'(want.rec.mark), 64'(o_found_mark));
                    check_field("last", 64'(want.last), 64'(o_last));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= stall_share(1'b0));
        end
    end

    // Keys believed live, in table order; only used to steer stimulus
    // towards hits, duplicates and a full table.
    logic signed [31:0] live_keys[$];

    function automatic void push_req(logic [2:0] op, t_rec rec);
        int at;
        queued_requests.push_back('{op: op, rec: rec});
        if (op == OP_INSERT && live_keys.size() < DEPTH) begin
            live_keys.push_back(rec.key);
        end else if (op == OP_DELETE) begin
            at = -1;
            for (int i = live_keys.size() - 1; i >= 0; i--)
                if (live_keys[i] == rec.key) at = i;
            if (at >= 0) live_keys.delete(at);
        end
    endfunction

    function automatic t_rec random_rec(logic signed [31:0] k);
        t_rec r;
        r.key  = k;
        r.name = {$urandom(), $urandom()};
        r.age  = 8'($urandom_range(0, 255));
        r.mark = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    // Stimulus, reset and end of run
    initial begin
        int                 n;
        int                 roll;
        int                 pick;
        logic [2:0]         op;
        logic signed [31:0] k;

        // directed opening: empty table first
        push_req(OP_LIST,   random_rec(32'sd0));
        push_req(OP_SEARCH, random_rec(32'sd0));
        push_req(OP_UPDATE, random_rec(32'sd5));
        push_req(OP_DELETE, random_rec(-32'sd1));
        // field extremes, plus a duplicate key
        push_req(OP_INSERT, '{key: KEY_MIN, name: '1, age: '1, mark: '1});
        push_req(OP_INSERT, '{key: KEY_MAX, name: '0, age: '0, mark: '0});
        push_req(OP_INSERT, random_rec(32'sd0));
        push_req(OP_INSERT, random_rec(KEY_MAX));
        // lookups land on the oldest of the duplicates
        push_req(OP_SEARCH, random_rec(KEY_MAX));
        push_req(OP_UPDATE, random_rec(KEY_MAX));
        push_req(OP_SEARCH, random_rec(KEY_MAX));
        push_req(OP_SEARCH, random_rec(32'sd12345));
        push_req(OP_UPDATE, random_rec(-32'sd7));
        // spare opcodes are swallowed
        for (int s = FIRST_SPARE_OP; s <= LAST_SPARE_OP; s++)
            push_req(3'(s), random_rec(KEY_MAX));
        push_req(OP_LIST,   random_rec(32'sd0));
        // delete from the middle, then the head, then the tail
        push_req(OP_DELETE, random_rec(KEY_MAX));
        push_req(OP_SEARCH, random_rec(KEY_MAX));
        push_req(OP_DELETE, random_rec(KEY_MIN));
        push_req(OP_LIST,   random_rec(32'sd0));
        push_req(OP_DELETE, random_rec(KEY_MAX));
        push_req(OP_DELETE, random_rec(32'sd0));
        push_req(OP_LIST,   random_rec(32'sd0));

        // Random part: fill past full, then a mixed stretch, then drain.
        n = 0;
        while (n < RANDOM_REQS) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 3) begin
                // noise request: ignored, not counted
                push_req(3'($urandom_range(FIRST_SPARE_OP, LAST_SPARE_OP)),
                         random_rec($urandom()));
            end else begin
                if (n < 110)
                    op = roll < 80 ? OP_INSERT : roll < 88 ? OP_SEARCH :
                         roll < 93 ? OP_UPDATE : roll < 98 ? OP_DELETE : OP_LIST;
                else if (n < 180)
                    op = roll < 30 ? OP_INSERT : roll < 55 ? OP_SEARCH :
                         roll < 75 ? OP_UPDATE : roll < 96 ? OP_DELETE : OP_LIST;
                else
                    op = roll < 10 ? OP_INSERT : roll < 25 ? OP_SEARCH :
                         roll < 35 ? OP_UPDATE : roll < 96 ? OP_DELETE : OP_LIST;
                k = $urandom();
                if (live_keys.size() > 0) begin
                    pick = $urandom_range(0, live_keys.size() - 1);
                    // inserts reuse a key now and then; lookups mostly hit
                    if (op == OP_INSERT ? $urandom_range(0, 3) == 0
                                        : $urandom_range(0, 9) < 8)
                        k = live_keys[pick];
                end
                push_req(op, random_rec(k));
                n++;
            end
        end
        total_reqs = queued_requests.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all requests taken and every due result seen
        do @(negedge i_clk);
        while (queued_requests.size() != 0 || in_valid || due_records.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (!mismatch)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/krt_pkg.sv
hw/rtl/krt_ram.sv
hw/rtl/krt_ctrl.sv
hw/rtl/krt_datapath.sv
hw/rtl/keyed_record_table_top.sv
verif/tb.sv
